// ===== sv/limit_order_book_matcher_unit_defines.svh =====
// assertion macros used by the order book rtl
`ifndef LIMIT_ORDER_BOOK_MATCHER_UNIT_DEFINES_SVH
`define LIMIT_ORDER_BOOK_MATCHER_UNIT_DEFINES_SVH

// implication checked in the same cycle
`define LOBM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the next cycle
`define LOBM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/lobm_pkg.sv =====
`timescale 1ns / 1ps
package lobm_pkg;

    // default sizes
    localparam int ORDER_SLOTS_DEF = 32;
    localparam int MAX_LEVELS_DEF  = 8;

    // resting order word: side, price, remaining, id
    localparam int SLOT_W = 73;

    localparam logic [3:0] DEPTH_RESET = 4'd5;

    // request codes
    localparam logic [1:0] REQ_SUBMIT = 2'd0;
    localparam logic [1:0] REQ_CANCEL = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;
    localparam logic [1:0] REQ_NONE   = 2'd3;

    localparam logic SIDE_BUY = 1'b0;

    // result kinds
    localparam logic [1:0] KIND_TRADE  = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_BID    = 2'd2;
    localparam logic [1:0] KIND_ASK    = 2'd3;

    // status codes
    localparam logic [2:0] STAT_FILLED    = 3'd0;
    localparam logic [2:0] STAT_PARTIAL   = 3'd1;
    localparam logic [2:0] STAT_ACCEPTED  = 3'd2;
    localparam logic [2:0] STAT_CANCELLED = 3'd3;
    localparam logic [2:0] STAT_MISSING   = 3'd4;
    localparam logic [2:0] STAT_BOOK_FULL = 3'd5;
    localparam logic [2:0] STAT_CLEARED   = 3'd6;

    typedef struct packed {
        logic [1:0]  req_type;
        logic        side;
        logic        is_market;
        logic [15:0] limit_price;
        logic [23:0] order_qty;
        logic [31:0] cancel_id;
    } t_req;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [2:0]  status_code;
        logic [31:0] taker_id;
        logic [31:0] maker_id;
        logic [15:0] out_price;
        logic [28:0] out_qty;
        logic [5:0]  trade_number;
        logic        last;
    } t_res;

endpackage

// ===== sv/lobm_ram.sv =====
`timescale 1ns / 1ps
module lobm_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);
    logic [W-1:0] r_mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== sv/lobm_front.sv =====
`timescale 1ns / 1ps
module lobm_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  lobm_pkg::t_req i_req,
    output logic          o_busy,
    input  logic          i_pop,
    output logic          o_vld,
    output lobm_pkg::t_req o_req
);
    import lobm_pkg::*;

    t_req       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    // unknown requests are taken and dropped
    assign o_busy = (r_cnt == 2'd2);
    assign w_push = i_start && !o_busy && (i_req.req_type != REQ_NONE);
    assign w_pop  = i_pop && (r_cnt != 2'd0);
    assign o_vld  = (r_cnt != 2'd0);
    assign o_req  = r_q[r_rp];

    // two-entry item queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= i_req;
                r_wp      <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!w_push && w_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end
endmodule

// ===== sv/lobm_back.sv =====
`timescale 1ns / 1ps
`include "limit_order_book_matcher_unit_defines.svh"
module lobm_back #(
    parameter int ORDER_SLOTS = lobm_pkg::ORDER_SLOTS_DEF,
    parameter int MAX_LEVELS  = lobm_pkg::MAX_LEVELS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  lobm_pkg::t_req i_req,
    output logic           o_pop,
    input  logic           i_cfg_we,
    input  logic [3:0]     i_cfg_wdata,
    output logic           o_strobe,
    output lobm_pkg::t_res o_res
);
    import lobm_pkg::*;

    localparam int IW = $clog2(ORDER_SLOTS);
    localparam int CW = $clog2(ORDER_SLOTS + 1);
    localparam logic [CW-1:0] SLOTS_C = CW'(ORDER_SLOTS);
    localparam logic [3:0]    MAXLV_C = 4'(MAX_LEVELS);

    typedef enum logic [2:0] {
        ST_IDLE, ST_MATCH, ST_REST, ST_CXL, ST_SNAP, ST_FLUSH
    } t_state;

    t_state           r_state;
    t_req             r_req;
    logic [31:0]      r_seq;
    logic [31:0]      r_id;
    logic [23:0]      r_rem;
    logic [5:0]       r_trades;
    logic [3:0]       r_depth;
    logic [ORDER_SLOTS-1:0] r_valid;

    // scan pointer and read pipeline
    logic [CW-1:0]    r_addr;
    logic             r_pend;
    logic [IW-1:0]    r_pidx;
    logic [CW-1:0]    n_addr;
    logic             n_pend;
    logic [IW-1:0]    n_pidx;
    logic             w_scan_go;

    // best candidate of the current scan
    logic             r_found;
    logic [IW-1:0]    r_bidx;
    logic [15:0]      r_bp;
    logic [31:0]      r_bage;
    logic [23:0]      r_brem;
    logic [31:0]      r_bid;

    // snapshot walk
    logic             r_sside;
    logic [3:0]       r_lvl;
    logic             r_have_prev;
    logic [15:0]      r_prev;
    logic [28:0]      r_total;

    // one result held back so the final one can carry last
    t_res             r_hold;
    logic             r_hold_vld;

    logic [SLOT_W-1:0] w_q;
    logic              q_side;
    logic [15:0]       q_price;
    logic [23:0]       q_rem;
    logic [31:0]       q_id;
    logic [IW-1:0]     w_raddr;
    logic              w_we;
    logic [IW-1:0]     w_waddr;
    logic [SLOT_W-1:0] w_wdata;
    logic              w_done;
    logic              w_slot_ok;
    logic [31:0]       w_age;
    logic              w_cand_m;
    logic              w_better_m;
    logic              w_cross;
    logic [23:0]       w_fill;
    logic [23:0]       w_left;
    logic [23:0]       w_rem_next;
    logic              w_cand_s;
    logic              w_better_s;
    logic              w_cand_c;
    logic              w_free_any;
    logic [IW-1:0]     w_free_idx;
    logic              w_rest;
    logic [3:0]        w_depth;
    logic [2:0]        w_stat;
    logic              w_push;
    t_res              w_push_res;

    lobm_ram #(.W(SLOT_W), .DEPTH(ORDER_SLOTS)) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_q)
    );

    assign q_side  = w_q[72];
    assign q_price = w_q[71:56];
    assign q_rem   = w_q[55:32];
    assign q_id    = w_q[31:0];

    assign w_raddr   = (r_addr < SLOTS_C) ? r_addr[IW-1:0] : '0;
    assign w_done    = (r_addr == SLOTS_C) && !r_pend;
    assign w_slot_ok = r_pend && r_valid[r_pidx];
    assign o_pop     = (r_state == ST_IDLE) && i_vld;
    assign w_depth   = (r_depth > MAXLV_C) ? MAXLV_C : r_depth;

    // match candidate: opposite side, best price then oldest
    assign w_age      = r_seq - q_id;
    assign w_cand_m   = w_slot_ok && (q_side != r_req.side);
    assign w_better_m = !r_found
        || ((r_req.side == SIDE_BUY) ? (q_price < r_bp) : (q_price > r_bp))
        || ((q_price == r_bp) && (w_age > r_bage));
    assign w_cross    = r_found && (r_req.is_market
        || ((r_req.side == SIDE_BUY) ? (r_bp <= r_req.limit_price)
                                     : (r_bp >= r_req.limit_price)));
    assign w_fill     = (r_rem < r_brem) ? r_rem : r_brem;
    assign w_left     = r_brem - w_fill;
    assign w_rem_next = r_rem - w_fill;

    // snapshot candidate: this side, strictly past the previous level
    assign w_cand_s   = w_slot_ok && (q_side == r_sside) && (!r_have_prev
        || ((r_sside == SIDE_BUY) ? (q_price < r_prev) : (q_price > r_prev)));
    assign w_better_s = !r_found
        || ((r_sside == SIDE_BUY) ? (q_price > r_bp) : (q_price < r_bp));

    // cancel candidate: first slot with the id
    assign w_cand_c = w_slot_ok && (q_id == r_req.cancel_id) && !r_found;

    // lowest free slot
    always_comb begin
        w_free_any = 1'b0;
        w_free_idx = '0;
        for (int i = ORDER_SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free_any = 1'b1;
                w_free_idx = IW'(i);
            end
        end
    end

    // scan restart requests
    always_comb begin
        w_scan_go = 1'b0;
        case (r_state)
            ST_IDLE:  w_scan_go = i_vld && (i_req.req_type != REQ_CLEAR);
            ST_MATCH: w_scan_go = w_done && w_cross && (w_rem_next != 24'd0);
            ST_REST:  w_scan_go = 1'b1;
            ST_CXL:   w_scan_go = w_done;
            ST_SNAP:  w_scan_go = w_done
                && ((r_found && (r_lvl + 4'd1 < w_depth)) || (r_sside == SIDE_BUY));
            default:  w_scan_go = 1'b0;
        endcase
    end

    // scan pointer next value
    always_comb begin
        n_addr = r_addr;
        n_pend = 1'b0;
        n_pidx = r_pidx;
        if (r_addr != SLOTS_C) begin
            n_addr = r_addr + CW'(1);
            n_pend = 1'b1;
            n_pidx = r_addr[IW-1:0];
        end
        if (r_state == ST_IDLE) begin
            n_addr = SLOTS_C;
        end
        if (w_scan_go) begin
            n_addr = '0;
            n_pend = 1'b0;
        end
    end

    // request status
    assign w_rest = (r_rem != 24'd0) && !r_req.is_market;
    always_comb begin
        if (r_rem == 24'd0) begin
            w_stat = STAT_FILLED;
        end else if (w_rest && !w_free_any) begin
            w_stat = STAT_BOOK_FULL;
        end else if (r_rem < r_req.order_qty) begin
            w_stat = STAT_PARTIAL;
        end else begin
            w_stat = STAT_ACCEPTED;
        end
    end

    // slot writes: fill update or new resting order
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_bidx;
        w_wdata = {~r_req.side, r_bp, w_left, r_bid};
        if (r_state == ST_MATCH && w_done && w_cross) begin
            w_we = 1'b1;
        end else if (r_state == ST_REST && w_rest && w_free_any) begin
            w_we    = 1'b1;
            w_waddr = w_free_idx;
            w_wdata = {r_req.side, r_req.limit_price, r_rem, r_id};
        end
    end

    // result produced this cycle
    always_comb begin
        w_push     = 1'b0;
        w_push_res = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_vld && i_req.req_type == REQ_CLEAR) begin
                    w_push                 = 1'b1;
                    w_push_res.out_kind    = KIND_STATUS;
                    w_push_res.status_code = STAT_CLEARED;
                end
            end
            ST_MATCH: begin
                if (w_done && w_cross) begin
                    w_push                  = 1'b1;
                    w_push_res.out_kind     = KIND_TRADE;
                    w_push_res.taker_id     = r_id;
                    w_push_res.maker_id     = r_bid;
                    w_push_res.out_price    = r_bp;
                    w_push_res.out_qty      = 29'(w_fill);
                    w_push_res.trade_number = r_trades + 6'd1;
                end
            end
            ST_REST: begin
                w_push                 = 1'b1;
                w_push_res.out_kind    = KIND_STATUS;
                w_push_res.status_code = w_stat;
                w_push_res.taker_id    = r_id;
                w_push_res.out_qty     = r_req.is_market ? 29'd0 : 29'(r_rem);
            end
            ST_CXL: begin
                if (w_done) begin
                    w_push                 = 1'b1;
                    w_push_res.out_kind    = KIND_STATUS;
                    w_push_res.status_code = r_found ? STAT_CANCELLED : STAT_MISSING;
                    w_push_res.taker_id    = r_req.cancel_id;
                end
            end
            ST_SNAP: begin
                if (w_done && r_found) begin
                    w_push               = 1'b1;
                    w_push_res.out_kind  = r_sside ? KIND_ASK : KIND_BID;
                    w_push_res.out_price = r_bp;
                    w_push_res.out_qty   = r_total;
                end
            end
            default: begin
                w_push = 1'b0;
            end
        endcase
    end

    // sequencer, book state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_seq      <= '0;
            r_depth    <= DEPTH_RESET;
            r_valid    <= '0;
            r_addr     <= '0;
            r_pend     <= 1'b0;
            r_found    <= 1'b0;
            r_hold_vld <= 1'b0;
            o_strobe   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_depth <= i_cfg_wdata;
            end

            // scan step
            r_addr <= n_addr;
            r_pend <= n_pend;
            r_pidx <= n_pidx;

            case (r_state)
                ST_IDLE: begin
                    if (i_vld) begin
                        r_req <= i_req;
                        case (i_req.req_type)
                            REQ_CLEAR: begin
                                r_valid <= '0;
                                r_seq   <= '0;
                                r_state <= ST_FLUSH;
                            end
                            REQ_CANCEL: begin
                                r_found <= 1'b0;
                                r_state <= ST_CXL;
                            end
                            default: begin
                                r_seq    <= r_seq + 32'd1;
                                r_id     <= r_seq + 32'd1;
                                r_rem    <= i_req.order_qty;
                                r_trades <= '0;
                                r_found  <= 1'b0;
                                r_state  <= (i_req.order_qty == 24'd0) ? ST_REST : ST_MATCH;
                            end
                        endcase
                    end
                end
                ST_MATCH: begin
                    if (w_cand_m && w_better_m) begin
                        r_found <= 1'b1;
                        r_bidx  <= r_pidx;
                        r_bp    <= q_price;
                        r_bage  <= w_age;
                        r_brem  <= q_rem;
                        r_bid   <= q_id;
                    end
                    if (w_done) begin
                        if (w_cross) begin
                            r_rem    <= w_rem_next;
                            r_trades <= r_trades + 6'd1;
                            if (w_left == 24'd0) begin
                                r_valid[r_bidx] <= 1'b0;
                            end
                            if (w_rem_next != 24'd0) begin
                                r_found <= 1'b0;
                            end else begin
                                r_state <= ST_REST;
                            end
                        end else begin
                            r_state <= ST_REST;
                        end
                    end
                end
                ST_REST: begin
                    if (w_rest && w_free_any) begin
                        r_valid[w_free_idx] <= 1'b1;
                    end
                    r_sside     <= SIDE_BUY;
                    r_lvl       <= '0;
                    r_have_prev <= 1'b0;
                    r_found     <= 1'b0;
                    r_state     <= (w_depth == 4'd0) ? ST_FLUSH : ST_SNAP;
                end
                ST_CXL: begin
                    if (w_cand_c) begin
                        r_found <= 1'b1;
                        r_bidx  <= r_pidx;
                    end
                    if (w_done) begin
                        if (r_found) begin
                            r_valid[r_bidx] <= 1'b0;
                        end
                        r_sside     <= SIDE_BUY;
                        r_lvl       <= '0;
                        r_have_prev <= 1'b0;
                        r_found     <= 1'b0;
                        r_state     <= (w_depth == 4'd0) ? ST_FLUSH : ST_SNAP;
                    end
                end
                ST_SNAP: begin
                    if (w_cand_s) begin
                        if (w_better_s) begin
                            r_found <= 1'b1;
                            r_bp    <= q_price;
                            r_total <= 29'(q_rem);
                        end else if (q_price == r_bp) begin
                            r_total <= r_total + 29'(q_rem);
                        end
                    end
                    if (w_done) begin
                        r_found <= 1'b0;
                        if (r_found && (r_lvl + 4'd1 < w_depth)) begin
                            r_lvl       <= r_lvl + 4'd1;
                            r_prev      <= r_bp;
                            r_have_prev <= 1'b1;
                        end else if (r_sside == SIDE_BUY) begin
                            r_sside     <= ~SIDE_BUY;
                            r_lvl       <= '0;
                            r_have_prev <= 1'b0;
                        end else begin
                            r_state <= ST_FLUSH;
                        end
                    end
                end
                ST_FLUSH: begin
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            // output: release held result, final one marked last
            if (r_state == ST_FLUSH) begin
                o_strobe   <= r_hold_vld;
                o_res      <= {r_hold[$bits(t_res)-1:1], 1'b1};
                r_hold_vld <= 1'b0;
            end else if (w_push) begin
                o_strobe   <= r_hold_vld;
                o_res      <= r_hold;
                r_hold     <= w_push_res;
                r_hold_vld <= 1'b1;
            end else begin
                o_strobe <= 1'b0;
            end
        end
    end

    `LOBM_ASSERT_NOW(a_trade_nonzero, i_clk, i_rst_n, o_strobe && o_res.out_kind == KIND_TRADE, o_res.out_qty != 29'd0 && o_res.trade_number != 6'd0 && !o_res.last, "trade with zero qty or number, or marked last")
    `LOBM_ASSERT_NEXT(a_flush_emits_last, i_clk, i_rst_n, r_state == ST_FLUSH, o_strobe && o_res.last && !r_hold_vld, "request end without final result")
    `LOBM_ASSERT_NOW(a_pop_idle, i_clk, i_rst_n, o_pop, r_state == ST_IDLE && !r_hold_vld, "item taken while previous request open")
endmodule

// ===== sv/limit_order_book_matcher_unit.sv =====
`timescale 1ns / 1ps
// each request runs as a series of scans over all slots: one per fill, one more when a
//   remainder is left, the cancel search, one per reported level and one per side that
//   runs out before the depth; a clear needs no scan. One request at a time: the next
//   starts as the final result leaves, and a two-item queue takes items meanwhile
// receiver cannot stall; sync active-low reset empties the book, id counter 0, depth 5
module limit_order_book_matcher_unit #(
    parameter int ORDER_SLOTS = lobm_pkg::ORDER_SLOTS_DEF,
    parameter int MAX_LEVELS  = lobm_pkg::MAX_LEVELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic        i_side,
    input  logic        i_is_market,
    input  logic [15:0] i_limit_price,
    input  logic [23:0] i_order_qty,
    input  logic [31:0] i_cancel_id,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    output logic        o_strobe,
    output logic [1:0]  o_out_kind,
    output logic [2:0]  o_status_code,
    output logic [31:0] o_taker_id,
    output logic [31:0] o_maker_id,
    output logic [15:0] o_out_price,
    output logic [28:0] o_out_qty,
    output logic [5:0]  o_trade_number,
    output logic        o_last
);
    import lobm_pkg::*;

    t_req w_in;
    t_req w_q_req;
    logic w_q_vld;
    logic w_pop;
    t_res w_res;

    assign w_in.req_type    = i_req_type;
    assign w_in.side        = i_side;
    assign w_in.is_market   = i_is_market;
    assign w_in.limit_price = i_limit_price;
    assign w_in.order_qty   = i_order_qty;
    assign w_in.cancel_id   = i_cancel_id;

    // request intake and queue
    lobm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_req   (w_in),
        .o_busy  (busy),
        .i_pop   (w_pop),
        .o_vld   (w_q_vld),
        .o_req   (w_q_req)
    );

    // matching engine
    lobm_back #(.ORDER_SLOTS(ORDER_SLOTS), .MAX_LEVELS(MAX_LEVELS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (w_q_vld),
        .i_req       (w_q_req),
        .o_pop       (w_pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_res       (w_res)
    );

    assign o_out_kind     = w_res.out_kind;
    assign o_status_code  = w_res.status_code;
    assign o_taker_id     = w_res.taker_id;
    assign o_maker_id     = w_res.maker_id;
    assign o_out_price    = w_res.out_price;
    assign o_out_qty      = w_res.out_qty;
    assign o_trade_number = w_res.trade_number;
    assign o_last         = w_res.last;
endmodule
